FILE: hdl/b64sc_pkg.sv
// ----------------------------------------------------------------------------
// Base64 stream codec package
// Shared constants and the character mapping functions of the codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 1;
    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int ACC_W       = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DECODE_MODE  = 1'b0,
        REG_URL_ALPHABET = 1'b1
    } cfg_reg_t;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_PAD     = 8'h3D;

    localparam logic [6:0] DEC_INVALID = 7'd64;

    typedef logic [ACC_W-1:0] acc_t;

    // Low n bits set.
    function automatic acc_t low_mask(input logic [2:0] n);
        return (acc_t'(1) << n) - acc_t'(1);
    endfunction

    function automatic logic [7:0] enc_char(input logic [5:0] v, input logic url);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = CH_UPPER_A + {2'b00, v};
        end else if (v < 6'd52) begin
            c = CH_LOWER_A + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = CH_ZERO + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = url ? CH_DASH : CH_PLUS;
        end else begin
            c = url ? CH_UNDER : CH_SLASH;
        end
        return c;
    endfunction

    // Returns the 6-bit value of a character, or DEC_INVALID.
    function automatic logic [6:0] dec_char(input logic [7:0] c, input logic url);
        logic [6:0] v;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            v = 7'(c - CH_UPPER_A);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            v = 7'(c - CH_LOWER_A + 8'd26);
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            v = 7'(c - CH_ZERO + 8'd52);
        end else if (c == CH_PLUS || (url && c == CH_DASH)) begin
            v = 7'd62;
        end else if (c == CH_SLASH || (url && c == CH_UNDER)) begin
            v = 7'd63;
        end else begin
            v = DEC_INVALID;
        end
        return v;
    endfunction

endpackage

FILE: hdl/base64_stream_codec_top.sv
// ----------------------------------------------------------------------------
// Base64 stream codec
// Encodes bytes to Base64 characters or decodes characters to bytes.
// ----------------------------------------------------------------------------
// An accepted item is turned combinationally into all of its results (up to four), which are
// held in a small result buffer and then leave one per cycle on the output channel while
// out_ready is high. An item therefore occupies the block until its last result leaves: one
// or two characters per byte when encoding, up to four on the last byte of a message (flush
// and '=' padding), and at most one byte per character when decoding. The next item is taken
// in the same cycle the last buffered result is transferred, so a waiting item does not hold
// up the output. Configuration writes are taken at any time, clear the message state, and
// must only be issued while no results are outstanding.
module base64_stream_codec_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [b64sc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [b64sc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      in_byte,
    input  logic                            message_last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      out_byte,
    output logic                            byte_valid,
    output logic                            run_last,
    output logic                            message_end
);
    import b64sc_pkg::*;

    logic                 decode_reg;
    logic                 url_reg;
    acc_t                 accum_reg, accum_next;
    logic [3:0]           pend_reg, pend_next;
    logic [1:0]           mod_reg, mod_next;
    logic                 pad_reg, pad_next;

    logic [7:0]           res_reg [MAX_RESULTS];
    logic [7:0]           res_next [MAX_RESULTS];
    logic [RES_CNT_W-1:0] remain_reg, remain_next;
    logic [RES_IDX_W-1:0] head_reg;
    logic                 bare_reg, bare_next;
    logic                 last_reg;

    logic                 in_xfer, out_xfer, cfg_xfer;

    // Encode path
    logic [2:0]           ecnt;
    acc_t                 eacc;
    logic [3:0]           etot;
    logic [2:0]           esh;
    logic                 etwo;
    logic [2:0]           erem;
    acc_t                 eleft;

    // Decode path
    logic [2:0]           dcnt;
    logic [6:0]           didx;
    acc_t                 dacc;
    logic [3:0]           dtot;
    logic [2:0]           drem;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid & cfg_ready;
    assign in_xfer   = in_valid & in_ready;
    assign out_xfer  = out_valid & out_ready;

    // A new item may enter once the buffer is empty or its final result leaves now.
    assign in_ready  = (remain_reg == '0) ||
                       (remain_reg == RES_CNT_W'(1) && out_ready);

    assign out_valid   = (remain_reg != '0);
    assign out_byte    = res_reg[head_reg];
    assign byte_valid  = ~bare_reg;
    assign run_last    = (remain_reg == RES_CNT_W'(1));
    assign message_end = run_last & last_reg;

    always_comb
    begin
        ecnt  = (pend_reg > 4'd4) ? 3'd4 : pend_reg[2:0];
        eacc  = ((accum_reg & low_mask(ecnt)) << 8) | acc_t'(in_byte);
        etot  = {1'b0, ecnt} + 4'd8;
        esh   = 3'(etot - 4'd6);
        etwo  = (esh >= 3'd6);
        erem  = etwo ? 3'd0 : esh;
        eleft = eacc & low_mask(erem);

        dcnt  = (pend_reg > 4'd6) ? 3'd6 : pend_reg[2:0];
        didx  = dec_char(in_byte, url_reg);
        dacc  = ((accum_reg & low_mask(dcnt)) << 6) | acc_t'(didx[5:0]);
        dtot  = {1'b0, dcnt} + 4'd6;
        drem  = (dtot >= 4'd8) ? 3'(dtot - 4'd8) : dtot[2:0];

        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res_next[i] = 8'h00;
        end
        remain_next = '0;
        bare_next   = 1'b0;
        accum_next  = accum_reg;
        pend_next   = pend_reg;
        mod_next    = mod_reg;
        pad_next    = pad_reg;

        if (!decode_reg)
        begin
            res_next[remain_next[RES_IDX_W-1:0]] = enc_char(6'(eacc >> esh), url_reg);
            remain_next = remain_next + RES_CNT_W'(1);
            mod_next    = mod_next + 2'd1;
            if (etwo)
            begin
                res_next[remain_next[RES_IDX_W-1:0]] = enc_char(eacc[5:0], url_reg);
                remain_next = remain_next + RES_CNT_W'(1);
                mod_next    = mod_next + 2'd1;
            end
            accum_next = eleft;
            pend_next  = {1'b0, erem};
            if (message_last)
            begin
                if (erem != 3'd0)
                begin
                    res_next[remain_next[RES_IDX_W-1:0]] =
                        enc_char(6'(eleft << (3'd6 - erem)), url_reg);
                    remain_next = remain_next + RES_CNT_W'(1);
                    mod_next    = mod_next + 2'd1;
                end
                for (int p = 0; p < 3; p++)
                begin
                    if (!url_reg && mod_next != 2'd0)
                    begin
                        res_next[remain_next[RES_IDX_W-1:0]] = CH_PAD;
                        remain_next = remain_next + RES_CNT_W'(1);
                        mod_next    = mod_next + 2'd1;
                    end
                end
            end
        end
        else if (!pad_reg)
        begin
            if (in_byte == CH_PAD)
            begin
                pad_next = 1'b1;
            end
            else if (didx != DEC_INVALID)
            begin
                if (dtot >= 4'd8)
                begin
                    res_next[0] = 8'(dacc >> (dtot - 4'd8));
                    remain_next = RES_CNT_W'(1);
                end
                accum_next = dacc & low_mask(drem);
                pend_next  = {1'b0, drem};
            end
        end

        // A final item that yields nothing still closes the message with a bare marker.
        if (message_last && remain_next == '0)
        begin
            res_next[0] = 8'h00;
            remain_next = RES_CNT_W'(1);
            bare_next   = 1'b1;
        end

        if (message_last)
        begin
            accum_next = '0;
            pend_next  = '0;
            mod_next   = '0;
            pad_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_reg <= 1'b0;
            url_reg    <= 1'b0;
            accum_reg  <= '0;
            pend_reg   <= '0;
            mod_reg    <= '0;
            pad_reg    <= 1'b0;
            remain_reg <= '0;
            head_reg   <= '0;
            bare_reg   <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_xfer)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_DECODE_MODE:  decode_reg <= cfg_data[0];
                    REG_URL_ALPHABET: url_reg    <= cfg_data[0];
                    default:          ;
                endcase
                accum_reg <= '0;
                pend_reg  <= '0;
                mod_reg   <= '0;
                pad_reg   <= 1'b0;
            end
            else if (in_xfer)
            begin
                accum_reg <= accum_next;
                pend_reg  <= pend_next;
                mod_reg   <= mod_next;
                pad_reg   <= pad_next;
            end

            if (in_xfer)
            begin
                remain_reg <= remain_next;
                head_reg   <= '0;
                bare_reg   <= bare_next;
                last_reg   <= message_last;
            end
            else if (out_xfer)
            begin
                remain_reg <= remain_reg - RES_CNT_W'(1);
                head_reg   <= head_reg + RES_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

endmodule

FILE: hdl/b64sc_checker.sv
// ----------------------------------------------------------------------------
// Base64 stream codec checker
// Port-level assertions on the codec's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module b64sc_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_ready,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       byte_valid,
    input  logic       run_last,
    input  logic       message_end
);

    // The end of a message always closes the run of the item that caused it.
    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_end |-> run_last)
        else $error("message_end without run_last");

    // A bare end marker carries a zero byte and closes both the run and the message.
    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_byte == 8'h00 && run_last && message_end)
        else $error("malformed bare end marker");

    // No new item enters while more than one result of the current item is waiting.
    a_no_overtake: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> !in_ready)
        else $error("input taken while results are still buffered");

    // A stalled result is held until its transfer.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
        else $error("stalled result changed");

endmodule

bind base64_stream_codec_top b64sc_checker u_b64sc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .run_last    (run_last),
    .message_end (message_end)
);
